// ===== sv/hopper_phase_pd_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Hopper phase PD controller assertion macros
// Concurrent assertion wrappers clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef HOPPER_PHASE_PD_CONTROLLER_ASSERT_SVH
`define HOPPER_PHASE_PD_CONTROLLER_ASSERT_SVH

// Check while out of reset.
`define HPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define HPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/hpc_pkg.sv =====
// ----------------------------------------------------------------------------
// hpc_pkg
// Types, register map and constants of the hopper phase PD controller.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned LenW    = 18;
  localparam int unsigned ForceW  = 24;
  localparam int unsigned GainW   = 16;
  localparam int unsigned TorqueW = 48;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ErrW    = 49;
  localparam int unsigned MulW    = 33;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned AccW    = 68;
  localparam int unsigned SplitW  = 24;

  localparam logic signed [ErrW-1:0] OneQ16 = ErrW'(65536);

  localparam logic [1:0] JOINT_ROLL   = 2'd0;
  localparam logic [1:0] JOINT_PITCH  = 2'd1;
  localparam logic [1:0] JOINT_PISTON = 2'd2;

  typedef enum logic [2:0] {
    PH_FLIGHT      = 3'd0,
    PH_LOADING     = 3'd1,
    PH_COMPRESSION = 3'd2,
    PH_THRUST      = 3'd3,
    PH_UNLOADING   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    REG_COMPRESS_LENGTH = 3'd0,
    REG_THRUST_LENGTH   = 3'd1,
    REG_EXTENDED_LENGTH = 3'd2,
    REG_THRUST_FORCE    = 3'd3,
    REG_POSITION_GAIN   = 3'd4,
    REG_VELOCITY_GAIN   = 3'd5,
    REG_ATTITUDE_GAIN   = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_ATT = 2'd0,
    MUL_LO  = 2'd1,
    MUL_HI  = 2'd2
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_ATT  = 3'd1,
    ST_ERR  = 3'd2,
    ST_LO   = 3'd3,
    ST_HI   = 3'd4,
    ST_SUM  = 3'd5,
    ST_DONE = 3'd6
  } ctrl_state_e;

  typedef struct packed {
    logic                     foot_contact;
    logic signed [DataW-1:0]  vertical_velocity;
    logic signed [DataW-1:0]  roll_angle;
    logic signed [DataW-1:0]  pitch_angle;
    logic signed [DataW-1:0]  roll_position;
    logic signed [DataW-1:0]  pitch_position;
    logic signed [DataW-1:0]  piston_position;
    logic signed [DataW-1:0]  roll_velocity;
    logic signed [DataW-1:0]  pitch_velocity;
    logic signed [DataW-1:0]  piston_velocity;
  } in_t;

  typedef struct packed {
    logic signed [TorqueW-1:0] roll_torque;
    logic signed [TorqueW-1:0] pitch_torque;
    logic signed [TorqueW-1:0] piston_force;
    logic [2:0]                phase;
  } out_t;

  typedef struct packed {
    logic [LenW-1:0]          compress_length;
    logic [LenW-1:0]          thrust_length;
    logic [LenW-1:0]          extended_length;
    logic signed [ForceW-1:0] thrust_force;
    logic [GainW-1:0]         position_gain;
    logic [GainW-1:0]         velocity_gain;
    logic signed [DataW-1:0]  attitude_gain;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    compress_length: LenW'(62259),
    thrust_length:   LenW'(52429),
    extended_length: LenW'(63570),
    thrust_force:    ForceW'(327680),
    position_gain:   GainW'(2000),
    velocity_gain:   GainW'(500),
    attitude_gain:   DataW'(6553600)
  };

  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_e   mul_sel;
    logic       err_en;
    logic       acc_en;
    logic       sum_en;
    logic       out_load;
    logic [1:0] joint;
  } dp_cmd_t;

  typedef struct packed {
    logic att_phase;
  } dp_status_t;

endpackage

// ===== sv/hpc_regs.sv =====
// ----------------------------------------------------------------------------
// hpc_regs
// APB configuration registers of the hopper phase PD controller.
// ----------------------------------------------------------------------------
module hpc_regs import hpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_COMPRESS_LENGTH: cfg_d.compress_length = pwdata[LenW-1:0];
        REG_THRUST_LENGTH:   cfg_d.thrust_length   = pwdata[LenW-1:0];
        REG_EXTENDED_LENGTH: cfg_d.extended_length = pwdata[LenW-1:0];
        REG_THRUST_FORCE:    cfg_d.thrust_force    = pwdata[ForceW-1:0];
        REG_POSITION_GAIN:   cfg_d.position_gain   = pwdata[GainW-1:0];
        REG_VELOCITY_GAIN:   cfg_d.velocity_gain   = pwdata[GainW-1:0];
        REG_ATTITUDE_GAIN:   cfg_d.attitude_gain   = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COMPRESS_LENGTH: prdata = {{(DataW-LenW){1'b0}}, cfg_q.compress_length};
      REG_THRUST_LENGTH:   prdata = {{(DataW-LenW){1'b0}}, cfg_q.thrust_length};
      REG_EXTENDED_LENGTH: prdata = {{(DataW-LenW){1'b0}}, cfg_q.extended_length};
      REG_THRUST_FORCE:    prdata = {{(DataW-ForceW){1'b0}}, cfg_q.thrust_force};
      REG_POSITION_GAIN:   prdata = {{(DataW-GainW){1'b0}}, cfg_q.position_gain};
      REG_VELOCITY_GAIN:   prdata = {{(DataW-GainW){1'b0}}, cfg_q.velocity_gain};
      REG_ATTITUDE_GAIN:   prdata = cfg_q.attitude_gain;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/hpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpc_ctrl
// Sequencer: walks the three joints through the shared multiplier.
// ----------------------------------------------------------------------------
module hpc_ctrl import hpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  joint_q, joint_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        last_joint;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_joint  = (joint_q == JOINT_PISTON);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    joint_d = joint_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ATT;
          joint_d = JOINT_ROLL;
        end
      end
      ST_ATT: state_d = ST_ERR;
      ST_ERR: state_d = ST_LO;
      ST_LO:  state_d = ST_HI;
      ST_HI:  state_d = ST_SUM;
      ST_SUM: begin
        if (last_joint) begin
          state_d = ST_DONE;
        end else begin
          joint_d = joint_q + 2'd1;
          state_d = (status_i.att_phase && joint_q == JOINT_ROLL) ? ST_ATT : ST_ERR;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_ATT;
    cmd_o.joint   = joint_q;
    in_stall_o    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_ATT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ATT;
      end
      ST_ERR: cmd_o.err_en = 1'b1;
      ST_LO: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LO;
      end
      ST_HI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HI;
        cmd_o.acc_en  = 1'b1;
      end
      ST_SUM:  cmd_o.sum_en = 1'b1;
      ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      joint_q     <= JOINT_ROLL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      joint_q     <= joint_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/hpc_dp.sv =====
// ----------------------------------------------------------------------------
// hpc_dp
// Datapath: hop phase register, shared 33x33 multiplier, PD accumulate
// and 48-bit saturation.
// ----------------------------------------------------------------------------
module hpc_dp import hpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  cfg_t       cfg_i,
  input  in_t        in_i,
  output dp_status_t status_o,
  output out_t       out_o
);

  in_t                       in_q;
  phase_e                    phase_q, phase_d;
  logic                      entry_q, entry_d;
  logic signed [DataW:0]     q_s33, lim_comp, lim_thr, lim_ext;
  logic signed [DataW-1:0]   ang, pos, vel;
  logic signed [ErrW-1:0]    pos49, vel49, tgt49;
  logic signed [ErrW-1:0]    err_q, err_d;
  logic [GainW-1:0]          gain;
  logic signed [MulW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q, sum;
  logic signed [TorqueW-1:0] sat_val, torque_new;
  logic signed [TorqueW-1:0] roll_q, pitch_q, piston_q;
  out_t                      out_q;
  logic                      is_piston;

  assign q_s33    = {in_i.piston_position[DataW-1], in_i.piston_position};
  assign lim_comp = {{(DataW+1-LenW){1'b0}}, cfg_i.compress_length};
  assign lim_thr  = {{(DataW+1-LenW){1'b0}}, cfg_i.thrust_length};
  assign lim_ext  = {{(DataW+1-LenW){1'b0}}, cfg_i.extended_length};

  always_comb begin
    phase_d = phase_q;
    entry_d = entry_q;
    if (cmd_i.load) begin
      entry_d = 1'b0;
      case (phase_q)
        PH_LOADING: begin
          if (q_s33 < lim_comp) begin
            phase_d = PH_COMPRESSION;
          end
        end
        PH_COMPRESSION: begin
          if (q_s33 < lim_thr || in_i.piston_velocity[DataW-1]) begin
            phase_d = PH_THRUST;
            entry_d = 1'b1;
          end
        end
        PH_THRUST: begin
          if (q_s33 > lim_ext) begin
            phase_d = PH_UNLOADING;
          end
        end
        PH_UNLOADING: begin
          if (!in_i.foot_contact) begin
            phase_d = PH_FLIGHT;
          end
        end
        default: begin
          if (in_i.foot_contact && in_i.vertical_velocity[DataW-1]) begin
            phase_d = PH_LOADING;
          end
        end
      endcase
    end
  end

  assign status_o.att_phase = (phase_q == PH_COMPRESSION) || (phase_q == PH_THRUST);
  assign is_piston          = (cmd_i.joint == JOINT_PISTON);

  always_comb begin
    case (cmd_i.joint)
      JOINT_ROLL: begin
        ang = in_q.roll_angle;
        pos = in_q.roll_position;
        vel = in_q.roll_velocity;
      end
      JOINT_PITCH: begin
        ang = in_q.pitch_angle;
        pos = in_q.pitch_position;
        vel = in_q.pitch_velocity;
      end
      default: begin
        ang = in_q.pitch_angle;
        pos = in_q.piston_position;
        vel = in_q.piston_velocity;
      end
    endcase
  end

  assign gain  = (phase_q == PH_FLIGHT) ? cfg_i.position_gain : cfg_i.velocity_gain;
  assign pos49 = {{(ErrW-DataW){pos[DataW-1]}}, pos};
  assign vel49 = {{(ErrW-DataW){vel[DataW-1]}}, vel};
  assign tgt49 = {prod_q[2*DataW-1], prod_q[2*DataW-1:FracW]};

  always_comb begin
    case (phase_q)
      PH_LOADING:     err_d = is_piston ? '0 : -vel49;
      PH_COMPRESSION: err_d = is_piston ? -vel49 : tgt49 - vel49;
      PH_THRUST:      err_d = is_piston ? '0 : tgt49 - vel49;
      PH_UNLOADING:   err_d = -vel49;
      default:        err_d = is_piston ? OneQ16 - pos49 : -pos49;
    endcase
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ATT: begin
        mul_a = {cfg_i.attitude_gain[DataW-1], cfg_i.attitude_gain};
        mul_b = {ang[DataW-1], ang};
      end
      MUL_LO: begin
        mul_a = {{(MulW-GainW){1'b0}}, gain};
        mul_b = {{(MulW-SplitW){1'b0}}, err_q[SplitW-1:0]};
      end
      MUL_HI: begin
        mul_a = {{(MulW-GainW){1'b0}}, gain};
        mul_b = {{(MulW-(ErrW-SplitW)){err_q[ErrW-1]}}, err_q[ErrW-1:SplitW]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum = acc_q + (AccW'(prod_q) <<< SplitW);

  always_comb begin
    if ((&sum[AccW-1:TorqueW-1]) || !(|sum[AccW-1:TorqueW-1])) begin
      sat_val = sum[TorqueW-1:0];
    end else if (sum[AccW-1]) begin
      sat_val = {1'b1, {(TorqueW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(TorqueW-1){1'b1}}};
    end
  end

  always_comb begin
    if (is_piston && phase_q == PH_THRUST && entry_q) begin
      torque_new = {{(TorqueW-ForceW){cfg_i.thrust_force[ForceW-1]}}, cfg_i.thrust_force};
    end else begin
      torque_new = sat_val;
    end
  end

  assign out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLIGHT;
      entry_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
    end
    if (cmd_i.err_en) begin
      err_q <= err_d;
    end
    if (cmd_i.acc_en) begin
      acc_q <= AccW'(prod_q);
    end
    if (cmd_i.sum_en) begin
      case (cmd_i.joint)
        JOINT_ROLL:  roll_q   <= torque_new;
        JOINT_PITCH: pitch_q  <= torque_new;
        default:     piston_q <= torque_new;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.roll_torque  <= roll_q;
      out_q.pitch_torque <= pitch_q;
      out_q.piston_force <= piston_q;
      out_q.phase        <= phase_q;
    end
  end

endmodule

// ===== sv/hopper_phase_pd_controller.sv =====
// ----------------------------------------------------------------------------
// Hopper phase PD controller
// One input word per control tick: foot contact, body vertical velocity,
// roll/pitch attitude and position/velocity of the roll, pitch and piston
// joints. The block steps the hop phase (flight, loading, compression,
// thrust, unloading) at most once and returns one output word with the
// three saturated joint torques and the new phase.
// Both channels use valid/stall; a word moves when valid is high and stall
// low. Gains and phase thresholds sit in APB registers at 4*index.
// The next word is taken only after the current result is loaded into the
// output register. One 33x33 multiplier is shared by all joints and is used
// two or three times per joint.
// A finished word waits in the output register while the receiver stalls;
// the block takes the next input meanwhile and holds its own result until
// the register frees. Reset returns to flight and loads the default gains.
// ----------------------------------------------------------------------------
module hopper_phase_pd_controller import hpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  hpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hpc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .cfg_i    (cfg),
    .in_i     (in_data_i),
    .status_o (status),
    .out_o    (out_data_o)
  );

endmodule

// ===== sv/hpc_checker.sv =====
// ----------------------------------------------------------------------------
// hpc_checker
// Port-level checks of the hopper phase PD controller, bound to the top.
// ----------------------------------------------------------------------------
`include "hopper_phase_pd_controller_assert.svh"

module hpc_checker import hpc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic in_acc;
  logic out_held;
  logic out_loading;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign out_loading = out_valid_o && (out_data_o.phase == PH_LOADING);

  `HPC_ASSERT(a_busy_after_accept, in_acc |=> in_stall_o && !$rose(out_valid_o), "overrun")
  `HPC_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_data_o), "stalled word changed")
  `HPC_ASSERT(a_loading_piston_zero, out_loading |-> out_data_o.piston_force == '0, "piston force")
  `HPC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid during reset")

endmodule

bind hopper_phase_pd_controller hpc_checker u_hpc_checker (.*);

// ===== tb/sv/hpc_torque_checker.sv =====
// ----------------------------------------------------------------------------
// Hopper phase PD controller torque checker
// Watches the input, output and register channels of the controller. Each
// accepted input word steps a private copy of the hop phase and the register
// file and yields the expected torque word, which waits in order until the
// block hands back its output word. Reports the first mismatches in full and
// counts the rest.
// ----------------------------------------------------------------------------
module hpc_torque_checker import hpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_t              in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_t             out_data_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;
  localparam logic signed [79:0] TorqueMax = 80'sh7FFF_FFFF_FFFF;
  localparam logic signed [79:0] TorqueMin = ~TorqueMax;

  cfg_t   cfg;
  phase_e hop_st;
  out_t   torque_q[$];
  out_t   want;
  int     errs;

  function automatic logic signed [TorqueW-1:0] servo(input logic signed [63:0] pos_err,
                                                      input logic signed [63:0] vel_err);
    logic signed [79:0] acc;
    acc = $signed({1'b0, cfg.position_gain}) * pos_err
        + $signed({1'b0, cfg.velocity_gain}) * vel_err;
    if (acc > TorqueMax) return TorqueMax[TorqueW-1:0];
    if (acc < TorqueMin) return TorqueMin[TorqueW-1:0];
    return acc[TorqueW-1:0];
  endfunction

  function automatic out_t step_hop(input in_t w);
    logic signed [63:0] q_r, q_p, q_s, v_r, v_p, v_s;
    logic signed [63:0] lim_c, lim_t, lim_e, att_r, att_p;
    phase_e ph;
    logic   entry;
    out_t   r;
    q_r   = $signed(w.roll_position);
    q_p   = $signed(w.pitch_position);
    q_s   = $signed(w.piston_position);
    v_r   = $signed(w.roll_velocity);
    v_p   = $signed(w.pitch_velocity);
    v_s   = $signed(w.piston_velocity);
    lim_c = $signed({46'd0, cfg.compress_length});
    lim_t = $signed({46'd0, cfg.thrust_length});
    lim_e = $signed({46'd0, cfg.extended_length});
    ph    = hop_st;
    entry = 1'b0;
    case (ph)
      PH_FLIGHT: begin
        if (w.foot_contact && w.vertical_velocity[DataW-1]) ph = PH_LOADING;
      end
      PH_LOADING: begin
        if (q_s < lim_c) ph = PH_COMPRESSION;
      end
      PH_COMPRESSION: begin
        if (q_s < lim_t || v_s < 0) begin
          ph    = PH_THRUST;
          entry = 1'b1;
        end
      end
      PH_THRUST: begin
        if (q_s > lim_e) ph = PH_UNLOADING;
      end
      default: begin
        if (!w.foot_contact) ph = PH_FLIGHT;
      end
    endcase
    hop_st = ph;
    att_r = $signed(cfg.attitude_gain) * $signed(w.roll_angle);
    att_p = $signed(cfg.attitude_gain) * $signed(w.pitch_angle);
    att_r = att_r >>> FracW;
    att_p = att_p >>> FracW;
    case (ph)
      PH_LOADING: begin
        r.roll_torque  = servo('0, -v_r);
        r.pitch_torque = servo('0, -v_p);
        r.piston_force = '0;
      end
      PH_COMPRESSION, PH_THRUST: begin
        r.roll_torque  = servo('0, att_r - v_r);
        r.pitch_torque = servo('0, att_p - v_p);
        if (ph == PH_COMPRESSION) r.piston_force = servo('0, -v_s);
        else if (entry) r.piston_force = TorqueW'($signed(cfg.thrust_force));
        else r.piston_force = '0;
      end
      PH_UNLOADING: begin
        r.roll_torque  = servo('0, -v_r);
        r.pitch_torque = servo('0, -v_p);
        r.piston_force = servo('0, -v_s);
      end
      default: begin
        r.roll_torque  = servo(-q_r, '0);
        r.pitch_torque = servo(-q_p, '0);
        r.piston_force = servo(64'sd65536 - q_s, '0);
      end
    endcase
    r.phase = ph;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg    = CfgReset;
      hop_st = PH_FLIGHT;
      torque_q.delete();
      errs   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (torque_q.size() == 0) begin
          errs++;
          if (errs <= MaxReports)
            $display("%0t unexpected word: roll %0d pitch %0d piston %0d phase %0d", $time,
                     out_data_i.roll_torque, out_data_i.pitch_torque,
                     out_data_i.piston_force, out_data_i.phase);
        end else begin
          want = torque_q.pop_front();
          if (out_data_i.roll_torque !== want.roll_torque ||
              out_data_i.pitch_torque !== want.pitch_torque ||
              out_data_i.piston_force !== want.piston_force ||
              out_data_i.phase !== want.phase) begin
            errs++;
            if (errs <= MaxReports) begin
              $display("%0t mismatch: expected roll %0d pitch %0d piston %0d phase %0d",
                       $time, want.roll_torque, want.pitch_torque, want.piston_force,
                       want.phase);
              $display("%0t   got roll %0d pitch %0d piston %0d phase %0d", $time,
                       out_data_i.roll_torque, out_data_i.pitch_torque,
                       out_data_i.piston_force, out_data_i.phase);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) torque_q.push_back(step_hop(in_data_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          REG_COMPRESS_LENGTH: cfg.compress_length = pwdata_i[LenW-1:0];
          REG_THRUST_LENGTH:   cfg.thrust_length   = pwdata_i[LenW-1:0];
          REG_EXTENDED_LENGTH: cfg.extended_length = pwdata_i[LenW-1:0];
          REG_THRUST_FORCE:    cfg.thrust_force    = pwdata_i[ForceW-1:0];
          REG_POSITION_GAIN:   cfg.position_gain   = pwdata_i[GainW-1:0];
          REG_VELOCITY_GAIN:   cfg.velocity_gain   = pwdata_i[GainW-1:0];
          REG_ATTITUDE_GAIN:   cfg.attitude_gain   = pwdata_i;
          default: ;
        endcase
      end
    end
    fail_cnt_o <= errs;
    pending_o  <= torque_q.size();
  end

endmodule

// ===== tb/sv/tb_hopper_phase_pd_controller.sv =====
// ----------------------------------------------------------------------------
// Hopper phase PD controller testbench
// Walks the hop cycle through every phase and threshold edge with directed
// control ticks, then runs random ticks under several register settings,
// the extremes among them. Both channels idle and stall at random; the
// receiver once holds off long enough to back up the block, and the sender
// once drains the block mid-run. The checker predicts every output word.
// ----------------------------------------------------------------------------
module tb_hopper_phase_pd_controller import hpc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 20;
  localparam int EndCycles    = 40;
  localparam int HoldCycles   = 300;
  localparam int QuietLimit   = 4000;
  localparam int ChunkTicks   = 115;

  localparam logic [2:0] RegUnused = 3'd7;

  localparam logic signed [31:0] IntMin     = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CompressAt = 32'(CfgReset.compress_length);
  localparam logic signed [31:0] ThrustAt   = 32'(CfgReset.thrust_length);
  localparam logic signed [31:0] ExtendAt   = 32'(CfgReset.extended_length);

  logic             clk_i;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int          fail_cnt;
  int          pending;
  int          quiet = 0;
  logic        steady = 1'b0;
  logic        hold_req = 1'b0;
  logic [LenW-1:0] near_len[3] = '{CfgReset.compress_length, CfgReset.thrust_length,
                                   CfgReset.extended_length};

  hopper_phase_pd_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  hpc_torque_checker torque_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet <= 0;
    else if (quiet >= QuietLimit) begin
      $display("tb_hopper_phase_pd_controller: FAIL");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // stall the output side; hold off for a long stretch on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall = !steady && ($urandom_range(99) < 37);
    end
  end

  function automatic in_t mk_tick(logic c, logic signed [31:0] vz, ar, ap, qr, qp, qs,
                                  vr, vp, vs);
    in_t w;
    w.foot_contact      = c;
    w.vertical_velocity = vz;
    w.roll_angle        = ar;
    w.pitch_angle       = ap;
    w.roll_position     = qr;
    w.pitch_position    = qp;
    w.piston_position   = qs;
    w.roll_velocity     = vr;
    w.pitch_velocity    = vp;
    w.piston_velocity   = vs;
    return w;
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0: return IntMin;
          1: return IntMax;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(262143)) - 131072;
    endcase
  endfunction

  function automatic in_t rand_tick();
    in_t w;
    w = mk_tick($urandom_range(9) < 6, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
    // aim the piston at a phase threshold
    if ($urandom_range(9) < 4)
      w.piston_position = $signed({14'd0, near_len[$urandom_range(2)]})
                        + $signed($urandom_range(4)) - 2;
    return w;
  endfunction

  function automatic logic [DataW-1:0] setting_value(int set_no, reg_idx_e r);
    case (set_no)
      1: begin
        case (r)
          REG_THRUST_FORCE:  return 32'h007F_FFFF;
          REG_POSITION_GAIN: return 32'h0000_FFFF;
          REG_ATTITUDE_GAIN: return 32'h7FFF_FFFF;
          default:           return 32'hFFFF_FFFF;
        endcase
      end
      2: begin
        case (r)
          REG_THRUST_FORCE:  return 32'h0080_0000;
          REG_ATTITUDE_GAIN: return 32'h8000_0000;
          default:           return '0;
        endcase
      end
      3: begin
        case (r)
          REG_THRUST_FORCE:  return 32'hABFF_FFFF;
          REG_POSITION_GAIN: return 32'h0000_0001;
          REG_VELOCITY_GAIN: return 32'h0000_FFFF;
          REG_ATTITUDE_GAIN: return 32'hFF9C_0000;
          default:           return 32'h0002_0000;
        endcase
      end
      default: begin
        case (r)
          REG_COMPRESS_LENGTH, REG_THRUST_LENGTH, REG_EXTENDED_LENGTH:
            return {14'($urandom_range(16383)), 18'($urandom_range(131072))};
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic push_tick(input in_t w);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] d);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'({idx, 2'b00});
    pwdata  = d;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_setting(input int set_no);
    reg_idx_e         r;
    logic [DataW-1:0] v;
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    for (int k = 0; k <= int'(REG_ATTITUDE_GAIN); k++) begin
      r = reg_idx_e'(k);
      v = setting_value(set_no, r);
      apb_write(r, v);
      case (r)
        REG_COMPRESS_LENGTH: near_len[0] = v[LenW-1:0];
        REG_THRUST_LENGTH:   near_len[1] = v[LenW-1:0];
        REG_EXTENDED_LENGTH: near_len[2] = v[LenW-1:0];
        default: ;
      endcase
    end
    if (set_no == 4) apb_write(RegUnused, $urandom);
  endtask

  task automatic run_chunk(input logic with_hold, input logic with_pause);
    for (int i = 0; i < ChunkTicks; i++) begin
      push_tick(rand_tick());
      if (with_hold && i == 40) hold_req = 1'b1;
      if (with_pause && i == ChunkTicks / 2) drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_tick(mk_tick(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_tick(mk_tick(1'b1, 0, IntMax, IntMin, IntMin, IntMax, IntMin, IntMax, IntMin, IntMax));
    push_tick(mk_tick(1'b0, IntMin, 0, 0, IntMax, IntMin, IntMax, 0, 0, 0));
    push_tick(mk_tick(1'b1, -1, 0, 0, 100, -100, 65536, IntMin, IntMax, 5));
    push_tick(mk_tick(1'b1, 0, 0, 0, 0, 0, CompressAt, IntMax, IntMin, IntMax));
    push_tick(mk_tick(1'b0, 0, IntMax, IntMin, 0, 0, CompressAt - 1, 7, -7, 3));
    push_tick(mk_tick(1'b1, 0, IntMin, IntMax, 0, 0, ThrustAt, IntMin, IntMax, 0));
    push_tick(mk_tick(1'b1, 0, 65536, -65536, 0, 0, ThrustAt - 1, 1, -1, 1));
    push_tick(mk_tick(1'b1, 0, -1, 1, 0, 0, ExtendAt, 0, 0, IntMin));
    push_tick(mk_tick(1'b1, 0, 3, -3, 0, 0, ExtendAt + 1, 0, 0, 0));
    push_tick(mk_tick(1'b1, IntMin, 0, 0, 0, 0, 0, IntMax, IntMin, IntMin));
    push_tick(mk_tick(1'b0, IntMax, 0, 0, 0, 0, 0, 0, 0, 0));
    push_tick(mk_tick(1'b1, IntMin, 0, 0, 5, 5, 0, 9, 9, 9));
    push_tick(mk_tick(1'b1, 0, 0, 0, 0, 0, IntMin, 0, 0, IntMax));
    push_tick(mk_tick(1'b1, 0, IntMax, IntMax, 0, 0, IntMax, 0, 0, -1));
    push_tick(mk_tick(1'b1, 0, IntMin, IntMin, 0, 0, IntMax, 0, 0, 0));
    push_tick(mk_tick(1'b0, 0, 0, 0, IntMin, IntMin, IntMin, 0, 0, 0));

    run_chunk(1'b1, 1'b0);
    apply_setting(1);
    run_chunk(1'b0, 1'b1);
    apply_setting(2);
    run_chunk(1'b0, 1'b0);
    apply_setting(3);
    run_chunk(1'b0, 1'b0);
    apply_setting(4);
    run_chunk(1'b0, 1'b0);
    apply_setting(5);
    steady = 1'b1;
    run_chunk(1'b0, 1'b0);
    steady = 1'b0;

    drain();
    repeat (EndCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_cnt == 0)
      $display("tb_hopper_phase_pd_controller: PASS");
    else
      $display("tb_hopper_phase_pd_controller: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hpc_pkg.sv
sv/hpc_regs.sv
sv/hpc_ctrl.sv
sv/hpc_dp.sv
sv/hopper_phase_pd_controller.sv
sv/hpc_checker.sv
tb/sv/hpc_torque_checker.sv
tb/sv/tb_hopper_phase_pd_controller.sv
